// ----- src/vbsp_pkg.sv -----
// Shared types and constants of the voice-file block stream parser.
`timescale 1ns / 1ps

package vbsp_pkg;

    // Default width of the saturating sample counter
    localparam int SAMPLE_COUNT_BITS_DEF = 32;

    // Rate divider: 1000000 / (256 - time constant)
    localparam int          RATE_W     = 20;
    localparam int          DEN_W      = 9;
    localparam logic [RATE_W-1:0] RATE_NUM  = 20'd1000000;
    localparam logic [DEN_W-1:0]  RATE_BASE = 9'd256;
    localparam logic [RATE_W-1:0] RATE_FROM = 20'd10989;
    localparam logic [RATE_W-1:0] RATE_TO   = 20'd11025;

    // File layout
    localparam logic [23:0] HDR_OFF_LO = 24'd20;
    localparam logic [23:0] HDR_OFF_HI = 24'd21;
    localparam logic [15:0] OFF_MIN    = 16'd22;
    localparam logic [7:0]  TYPE_MAX   = 8'd7;
    localparam logic [7:0]  SILENCE_VAL = 8'd128;

    // Block types
    localparam logic [2:0] BK_SOUND   = 3'd1;
    localparam logic [2:0] BK_CONT    = 3'd2;
    localparam logic [2:0] BK_SILENCE = 3'd3;
    localparam logic [2:0] BK_REPEAT  = 3'd6;
    localparam logic [2:0] BK_END_REP = 3'd7;

    // Output bus width: 142 bits of fields, padded to whole bytes
    localparam int TDATA_W = 144;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'd0,
        PH_SKIP    = 4'd1,
        PH_TYPE    = 4'd2,
        PH_LEN0    = 4'd3,
        PH_LEN1    = 4'd4,
        PH_LEN2    = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_DONE    = 4'd7
    } t_phase;

    typedef enum logic [2:0] {
        KIND_SAMPLE  = 3'd0,
        KIND_SILENCE = 3'd1,
        KIND_RATE    = 3'd2,
        KIND_LOOP_ST = 3'd3,
        KIND_LOOP_END = 3'd4,
        KIND_SUMMARY = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_EXEC = 3'd1,
        S_DIV  = 3'd2,
        S_EMIT = 3'd3,
        S_TAIL = 3'd4,
        S_SUM  = 3'd5
    } t_seq;

    typedef struct packed {
        t_kind        kind;
        logic [7:0]   sample_value;
        logic [15:0]  run_length;
        logic [19:0]  rate_hz;
        logic [31:0]  position;
        logic [31:0]  loop_begin;
        logic [31:0]  loop_finish;
        logic         looping;
        logic         file_ok;
        logic         last;
    } t_result;

endpackage

// ----- src/vbsp_div.sv -----
// Iterative restoring divider for the sample rate, one quotient bit a cycle.
`timescale 1ns / 1ps

module vbsp_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [vbsp_pkg::DEN_W-1:0]   i_divisor,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [vbsp_pkg::RATE_W-1:0]  o_quotient
);
    import vbsp_pkg::*;

    localparam int CNT_W = $clog2(RATE_W);

    logic [DEN_W-1:0]  r_rem;
    logic [RATE_W-1:0] r_quo;
    logic [DEN_W-1:0]  r_den;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DEN_W:0]    trial;
    logic              qbit;
    logic [DEN_W:0]    diff;

    // Shift in the next dividend bit and try a subtract
    always_comb begin
        trial = {r_rem, r_quo[RATE_W-1]};
        diff  = trial - {1'b0, r_den};
        qbit  = (trial >= {1'b0, r_den});
    end

    // Control: count steps, pulse done at the end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(RATE_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= RATE_NUM;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_quo <= {r_quo[RATE_W-2:0], qbit};
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

`ifndef SYNTHESIS
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> o_busy)
        else $error("divider not busy after start");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy) && !o_busy)
        else $error("divider done without a run");
    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_quotient <= RATE_NUM)
        else $error("divider quotient out of range");
`endif

endmodule

// ----- src/vbsp_out.sv -----
// Output register stage that holds one result until the receiver takes it.
`timescale 1ns / 1ps

module vbsp_out (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    input  vbsp_pkg::t_result                 i_res,
    output logic                              o_free,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // sample_value, run_length, rate_hz, position, loop_begin, loop_finish,
    // looping, file_ok, then two zero pad bits
    output logic [vbsp_pkg::TDATA_W-1:0]      m_axis_tdata,
    // kind
    output logic [2:0]                        m_axis_tuser,
    output logic                              m_axis_tlast
);
    import vbsp_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || m_axis_tready;

    // Hold the result while stalled, load a new one when free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_push) begin
            r_res <= i_res;
        end
    end

    // Pack fields from the lowest bit up
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {2'b00, r_res.file_ok, r_res.looping, r_res.loop_finish,
                            r_res.loop_begin, r_res.position, r_res.rate_hz,
                            r_res.run_length, r_res.sample_value};
    assign m_axis_tuser  = r_res.kind;
    assign m_axis_tlast  = r_res.last;

`ifndef SYNTHESIS
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_free)
        else $error("result pushed into a full output stage");
    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |=> m_axis_tvalid)
        else $error("pushed result not shown");
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_push && m_axis_tready |=> !m_axis_tvalid)
        else $error("output valid with nothing pushed");
`endif

endmodule

// ----- src/voc_block_stream_parser.sv -----
// Top level: byte sequencer of the voice-file block parser.
`timescale 1ns / 1ps
//
// Takes a voice audio file one byte per transfer on s_axis (tdata = byte,
// tlast = final byte of the file) and gives parsed results on m_axis
// (tuser = kind, tlast = final result caused by that byte). The rate remap
// register is written through i_cfg_we / i_cfg_wdata; the user must write it
// only while idle, as the block itself does not enforce this.
// Each byte runs through a small sequencer: decode, emit of a result (once
// the output stage is free), wrap-up; a byte that gives no result skips
// the emit step. The first payload byte of a sound block also runs the
// shared rate divider, one quotient bit a cycle, before its emit step. A
// final byte that needs a file summary adds one more emit step.
// s_axis_tready is high only between bytes. The output stage holds one
// result; while the receiver stalls, the sequencer waits in its emit step.
// Reset (synchronous, active low) returns the parser to the file header,
// clears the counters and sets the rate remap register to 1.
//
module voc_block_stream_parser #(
    parameter int SAMPLE_COUNT_BITS = vbsp_pkg::SAMPLE_COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // data_byte
    input  logic [7:0]                    s_axis_tdata,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // sample_value, run_length, rate_hz, position, loop_begin, loop_finish,
    // looping, file_ok, then two zero pad bits
    output logic [vbsp_pkg::TDATA_W-1:0]  m_axis_tdata,
    // kind
    output logic [2:0]                    m_axis_tuser,
    output logic                          m_axis_tlast
);
    import vbsp_pkg::*;

    localparam int SCB = SAMPLE_COUNT_BITS;

    function automatic logic [31:0] cap32(input logic [SCB-1:0] v);
        if ((v >> 32) != '0) return '1;
        return 32'(v);
    endfunction

    // Sequencer and handshake
    t_seq r_state, n_state;
    logic r_remap;
    logic [7:0] r_b;
    logic r_fin;
    t_result r_res;

    // Parser state
    t_phase          r_phase, n_phase;
    logic [23:0]     r_cnt, n_cnt;
    logic [15:0]     r_off, n_off;
    logic [2:0]      r_kind, n_kind;
    logic [7:0]      r_sil_lo, n_sil_lo;
    logic [1:0]      r_idx, n_idx;
    logic [SCB-1:0]  r_smp, n_smp;
    logic [SCB-1:0]  r_lstart, n_lstart;
    logic [SCB-1:0]  r_lend, n_lend;
    logic            r_lseen, n_lseen;
    logic            r_dseen, n_dseen;

    // Decode results
    t_result e_res, sum_res, push_res;
    logic e_has, e_rate;
    logic [15:0] e_add;
    logic [SCB:0] smp_sum;
    logic [15:0] off;
    logic [23:0] cnt_inc, cnt_dec, cnt_len;

    logic accept, need_sum, push, free, clear;
    logic div_start, div_busy, div_done;
    logic [RATE_W-1:0] div_q, rate_fix;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign need_sum = r_fin && (r_phase != PH_DONE);

    // Build the file summary from current state
    always_comb begin
        sum_res             = '0;
        sum_res.kind        = KIND_SUMMARY;
        sum_res.position    = cap32(r_smp);
        sum_res.loop_begin  = r_lseen ? cap32(r_lstart) : 32'd0;
        sum_res.loop_finish = r_lseen ? cap32(r_lend) : cap32(r_smp);
        sum_res.looping     = r_lseen;
        sum_res.file_ok     = r_dseen;
        sum_res.last        = 1'b1;
    end

    // Saturating sample count
    always_comb begin
        smp_sum = {1'b0, r_smp} + (SCB + 1)'(e_add);
    end

    // Decode one byte against the current phase
    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_off    = r_off;
        n_kind   = r_kind;
        n_sil_lo = r_sil_lo;
        n_idx    = r_idx;
        n_smp    = r_smp;
        n_lstart = r_lstart;
        n_lend   = r_lend;
        n_lseen  = r_lseen;
        n_dseen  = r_dseen;
        e_res    = '0;
        e_res.position = cap32(r_smp);
        e_has    = 1'b0;
        e_rate   = 1'b0;
        e_add    = '0;
        off      = {r_b, r_off[7:0]};
        cnt_inc  = r_cnt + 24'd1;
        cnt_dec  = r_cnt - 24'd1;
        cnt_len  = {r_b, r_cnt[15:0]};
        unique case (r_phase)
            PH_HEADER: begin
                if (r_cnt == HDR_OFF_LO) n_off = {8'd0, r_b};
                if (r_cnt == HDR_OFF_HI) begin
                    if (off < OFF_MIN) off = OFF_MIN;
                    n_off   = off;
                    n_phase = (off == OFF_MIN) ? PH_TYPE : PH_SKIP;
                end
                n_cnt = cnt_inc;
            end
            PH_SKIP: begin
                n_cnt = cnt_inc;
                if (cnt_inc >= {8'd0, r_off}) n_phase = PH_TYPE;
            end
            PH_TYPE: begin
                if (r_b == 8'd0 || r_b > TYPE_MAX) begin
                    e_res   = sum_res;
                    e_has   = 1'b1;
                    n_phase = PH_DONE;
                end else begin
                    n_kind  = r_b[2:0];
                    n_phase = PH_LEN0;
                end
            end
            PH_LEN0: begin
                n_cnt   = {16'd0, r_b};
                n_phase = PH_LEN1;
            end
            PH_LEN1: begin
                n_cnt   = {r_cnt[23:16], r_b, r_cnt[7:0]};
                n_phase = PH_LEN2;
            end
            PH_LEN2: begin
                n_cnt    = cnt_len;
                n_sil_lo = '0;
                n_idx    = '0;
                if (r_kind == BK_SOUND || r_kind == BK_CONT || r_kind == BK_SILENCE)
                    n_dseen = 1'b1;
                if (r_kind == BK_REPEAT) begin
                    e_res.kind = KIND_LOOP_ST;
                    e_has      = 1'b1;
                    n_lseen    = 1'b1;
                    n_lstart   = r_smp;
                end else if (r_kind == BK_END_REP) begin
                    e_res.kind = KIND_LOOP_END;
                    e_has      = 1'b1;
                    n_lend     = r_smp;
                end
                n_phase = (cnt_len == 24'd0) ? PH_TYPE : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                if (r_kind == BK_SOUND) begin
                    if (r_idx == 2'd0) begin
                        e_res.kind = KIND_RATE;
                        e_has      = 1'b1;
                        e_rate     = 1'b1;
                    end else if (r_idx == 2'd2) begin
                        e_res.kind         = KIND_SAMPLE;
                        e_res.sample_value = r_b;
                        e_has              = 1'b1;
                        e_add              = 16'd1;
                    end
                end else if (r_kind == BK_CONT) begin
                    e_res.kind         = KIND_SAMPLE;
                    e_res.sample_value = r_b;
                    e_has              = 1'b1;
                    e_add              = 16'd1;
                end else if (r_kind == BK_SILENCE) begin
                    if (r_idx == 2'd0) begin
                        n_sil_lo = r_b;
                    end else if (r_idx == 2'd1) begin
                        e_res.kind         = KIND_SILENCE;
                        e_res.sample_value = SILENCE_VAL;
                        e_res.run_length   = {r_b, r_sil_lo};
                        e_has              = 1'b1;
                        e_add              = {r_b, r_sil_lo};
                    end
                end
                if (e_add != '0) n_smp = smp_sum[SCB] ? '1 : smp_sum[SCB-1:0];
                if (r_idx != 2'd2) n_idx = r_idx + 2'd1;
                n_cnt = cnt_dec;
                if (cnt_dec == 24'd0) n_phase = PH_TYPE;
            end
            default: begin
            end
        endcase
    end

    // Next state of the sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_EXEC;
            S_EXEC: begin
                if (e_rate)     n_state = S_DIV;
                else if (e_has) n_state = S_EMIT;
                else            n_state = S_TAIL;
            end
            S_DIV:  if (div_done) n_state = S_EMIT;
            S_EMIT: if (free) n_state = S_TAIL;
            S_TAIL: n_state = need_sum ? S_SUM : S_IDLE;
            S_SUM:  if (free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        div_start     = (r_state == S_EXEC) && e_rate;
        push          = ((r_state == S_EMIT) || (r_state == S_SUM)) && free;
        clear         = ((r_state == S_TAIL) && r_fin && !need_sum)
                     || ((r_state == S_SUM) && free);
        push_res      = r_res;
        push_res.last = !need_sum;
        if (r_state == S_SUM) push_res = sum_res;
    end

    // Remap the common 11 kHz constant
    assign rate_fix = (r_remap && div_q == RATE_FROM) ? RATE_TO : div_q;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_remap  <= 1'b1;
            r_phase  <= PH_HEADER;
            r_cnt    <= '0;
            r_off    <= '0;
            r_kind   <= '0;
            r_sil_lo <= '0;
            r_idx    <= '0;
            r_smp    <= '0;
            r_lstart <= '0;
            r_lend   <= '0;
            r_lseen  <= 1'b0;
            r_dseen  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_remap <= i_cfg_wdata;
            if (clear) begin
                r_phase  <= PH_HEADER;
                r_cnt    <= '0;
                r_off    <= '0;
                r_kind   <= '0;
                r_sil_lo <= '0;
                r_idx    <= '0;
                r_smp    <= '0;
                r_lstart <= '0;
                r_lend   <= '0;
                r_lseen  <= 1'b0;
                r_dseen  <= 1'b0;
            end else if (r_state == S_EXEC) begin
                r_phase  <= n_phase;
                r_cnt    <= n_cnt;
                r_off    <= n_off;
                r_kind   <= n_kind;
                r_sil_lo <= n_sil_lo;
                r_idx    <= n_idx;
                r_smp    <= n_smp;
                r_lstart <= n_lstart;
                r_lend   <= n_lend;
                r_lseen  <= n_lseen;
                r_dseen  <= n_dseen;
            end
        end
    end

    // Payload registers: the byte being worked on and its pending result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b   <= s_axis_tdata;
            r_fin <= s_axis_tlast;
        end
        if (r_state == S_EXEC) r_res <= e_res;
        else if (r_state == S_DIV && div_done) r_res.rate_hz <= rate_fix;
    end

    vbsp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_divisor  (RATE_BASE - DEN_W'(r_b)),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    vbsp_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_res         (push_res),
        .o_free        (free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_one_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !s_axis_tready)
        else $error("second byte taken while one is in work");
    a_div_sound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> r_kind == BK_SOUND && r_phase == PH_PAYLOAD && !div_busy)
        else $error("rate divider started outside a sound block header");
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV && !div_done |-> div_busy)
        else $error("sequencer waits on an idle divider");
    a_sum_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && push_res.kind == KIND_SUMMARY |-> push_res.last)
        else $error("file summary not marked last");
`endif

endmodule

// ----- tb/tb_voc_block_stream_parser.sv -----
// Self-checking testbench for the voice-file block stream parser.
`timescale 1ns / 1ps

module tb_voc_block_stream_parser;

    import vbsp_pkg::*;

    // Block types without a package name, end-of-file type byte, special time constant
    localparam logic [2:0] BLK_MARKER  = 3'd4;
    localparam logic [2:0] BLK_TEXT    = 3'd5;
    localparam logic [7:0] TYPE_END    = 8'd0;
    localparam logic [7:0] TC_REMAP    = 8'd165;
    localparam int         STALL_LIMIT = 5000;
    localparam int         SETTLE_CYC  = 60;
    localparam int         PHASE_BYTES = 430;

    // Result predictor plus store of parsed results still to arrive
    class voc_scoreboard;
        bit          remap_en = 1'b1;
        t_phase      ph = PH_HEADER;
        logic [23:0] byte_cnt = '0;
        logic [15:0] data_off = '0;
        logic [2:0]  blk_kind = '0;
        logic [7:0]  sil_lo = '0;
        logic [1:0]  pay_idx = '0;
        logic [31:0] smp_cnt = '0;
        logic [31:0] loop_st = '0;
        logic [31:0] loop_en = '0;
        bit          loop_seen = 1'b0;
        bit          data_seen = 1'b0;
        t_result     parsed_results[$];
        int          errors = 0;
        int          checked = 0;
        int          bytes_parsed = 0;
        int          kinds_seen[6];

        function void clear_file();
            ph = PH_HEADER;
            byte_cnt = '0;
            data_off = '0;
            blk_kind = '0;
            sil_lo = '0;
            pay_idx = '0;
            smp_cnt = '0;
            loop_st = '0;
            loop_en = '0;
            loop_seen = 1'b0;
            data_seen = 1'b0;
        endfunction

        function t_result make_result(t_kind k);
            t_result r;
            r = '0;
            r.kind = k;
            r.position = smp_cnt;
            return r;
        endfunction

        // Append one expected result at the tail of the store
        function void queue_result(t_result r);
            parsed_results.insert(parsed_results.size(), r);
        endfunction

        // Saturating add to the sample position
        function void add_samples(logic [31:0] n);
            logic [32:0] s;
            s = {1'b0, smp_cnt} + {1'b0, n};
            smp_cnt = s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function void push_summary();
            t_result r;
            r = make_result(KIND_SUMMARY);
            r.loop_begin  = loop_seen ? loop_st : 32'd0;
            r.loop_finish = loop_seen ? loop_en : smp_cnt;
            r.looping     = loop_seen;
            r.file_ok     = data_seen;
            queue_result(r);
        endfunction

        // Advance the parser by one accepted byte and queue what it yields
        function void parse_byte(logic [7:0] b, bit fin);
            int unsigned first;
            int unsigned rate;
            logic [15:0] run;
            t_result     r;
            first = parsed_results.size();
            if (ph != PH_DONE) bytes_parsed++;
            case (ph)
                PH_HEADER: begin
                    if (byte_cnt == HDR_OFF_LO) data_off = {8'h00, b};
                    if (byte_cnt == HDR_OFF_HI) begin
                        data_off[15:8] = b;
                        if (data_off < OFF_MIN) data_off = OFF_MIN;
                        if (data_off == OFF_MIN) ph = PH_TYPE;
                        else ph = PH_SKIP;
                    end
                    byte_cnt++;
                end
                PH_SKIP: begin
                    byte_cnt++;
                    if (byte_cnt >= {8'h00, data_off}) ph = PH_TYPE;
                end
                PH_TYPE: begin
                    if (b == TYPE_END || b > TYPE_MAX) begin
                        push_summary();
                        ph = PH_DONE;
                    end else begin
                        blk_kind = b[2:0];
                        ph = PH_LEN0;
                    end
                end
                PH_LEN0: begin
                    byte_cnt = {16'h0000, b};
                    ph = PH_LEN1;
                end
                PH_LEN1: begin
                    byte_cnt[15:8] = b;
                    ph = PH_LEN2;
                end
                PH_LEN2: begin
                    byte_cnt[23:16] = b;
                    sil_lo = '0;
                    pay_idx = '0;
                    if (blk_kind >= BK_SOUND && blk_kind <= BK_SILENCE) data_seen = 1'b1;
                    if (blk_kind == BK_REPEAT) begin
                        queue_result(make_result(KIND_LOOP_ST));
                        loop_seen = 1'b1;
                        loop_st = smp_cnt;
                    end else if (blk_kind == BK_END_REP) begin
                        queue_result(make_result(KIND_LOOP_END));
                        loop_en = smp_cnt;
                    end
                    if (byte_cnt == 24'd0) ph = PH_TYPE;
                    else ph = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    case (blk_kind)
                        BK_SOUND: begin
                            if (pay_idx == 2'd0) begin
                                rate = 1000000 / (256 - int'(b));
                                if (remap_en && rate == int'(RATE_FROM))
                                    rate = int'(RATE_TO);
                                r = make_result(KIND_RATE);
                                r.rate_hz = rate[19:0];
                                queue_result(r);
                            end else if (pay_idx == 2'd2) begin
                                r = make_result(KIND_SAMPLE);
                                r.sample_value = b;
                                queue_result(r);
                                add_samples(32'd1);
                            end
                        end
                        BK_CONT: begin
                            r = make_result(KIND_SAMPLE);
                            r.sample_value = b;
                            queue_result(r);
                            add_samples(32'd1);
                        end
                        BK_SILENCE: begin
                            if (pay_idx == 2'd0) begin
                                sil_lo = b;
                            end else if (pay_idx == 2'd1) begin
                                run = {b, sil_lo};
                                r = make_result(KIND_SILENCE);
                                r.sample_value = SILENCE_VAL;
                                r.run_length = run;
                                queue_result(r);
                                add_samples({16'h0000, run});
                            end
                        end
                        default: ;
                    endcase
                    if (pay_idx < 2'd2) pay_idx++;
                    byte_cnt--;
                    if (byte_cnt == 24'd0) ph = PH_TYPE;
                end
                default: ;
            endcase
            // A final byte closes the file and rearms for the next one
            if (fin) begin
                if (ph != PH_DONE) push_summary();
                clear_file();
            end
            if (parsed_results.size() > first) parsed_results[$].last = 1'b1;
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 40) $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d field %s: got 0x%0h, want 0x%0h",
                                          checked, name, got, want));
        endtask

        task check_result(t_result got);
            t_result want;
            if (parsed_results.size() == 0) begin
                report_mismatch($sformatf("result of kind %0d with nothing pending",
                                          got.kind));
                return;
            end
            want = parsed_results.pop_front();
            compare_field("kind", 32'(got.kind), 32'(want.kind));
            compare_field("sample_value", 32'(got.sample_value), 32'(want.sample_value));
            compare_field("run_length", 32'(got.run_length), 32'(want.run_length));
            compare_field("rate_hz", 32'(got.rate_hz), 32'(want.rate_hz));
            compare_field("position", got.position, want.position);
            compare_field("loop_begin", got.loop_begin, want.loop_begin);
            compare_field("loop_finish", got.loop_finish, want.loop_finish);
            compare_field("looping", 32'(got.looping), 32'(want.looping));
            compare_field("file_ok", 32'(got.file_ok), 32'(want.file_ok));
            compare_field("last", 32'(got.last), 32'(want.last));
            if (want.kind <= KIND_SUMMARY) kinds_seen[int'(want.kind)]++;
            checked++;
        endtask
    endclass

    typedef struct {
        logic [7:0] value;
        bit         fin;
    } t_feed;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic                 i_cfg_wdata = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata = '0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic [2:0]           m_axis_tuser;
    logic                 m_axis_tlast;

    voc_scoreboard sb;
    t_feed         feed[$];
    t_result       bus_result;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            files_sent = 0;
    int            quiet_cycles = 0;

    voc_block_stream_parser i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Take results, check them, and pick the next ready level
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            bus_result.kind         = t_kind'(m_axis_tuser);
            bus_result.sample_value = m_axis_tdata[7:0];
            bus_result.run_length   = m_axis_tdata[23:8];
            bus_result.rate_hz      = m_axis_tdata[43:24];
            bus_result.position     = m_axis_tdata[75:44];
            bus_result.loop_begin   = m_axis_tdata[107:76];
            bus_result.loop_finish  = m_axis_tdata[139:108];
            bus_result.looping      = m_axis_tdata[140];
            bus_result.file_ok      = m_axis_tdata[141];
            bus_result.last         = m_axis_tlast;
            if (m_axis_tdata[143:142] !== 2'b00)
                sb.report_mismatch($sformatf("result %0d pad bits nonzero", sb.checked));
            sb.check_result(bus_result);
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic void push_byte(input logic [7:0] value);
        feed.insert(feed.size(), t_feed'{value, 1'b0});
    endfunction

    // File header with the data offset at bytes 20 and 21, then any skipped bytes
    function automatic void push_header(input logic [15:0] off);
        for (int i = 0; i < 20; i++) push_byte(8'($urandom));
        push_byte(off[7:0]);
        push_byte(off[15:8]);
        for (int i = 22; i < int'(off); i++) push_byte(8'($urandom));
    endfunction

    function automatic void push_block_head(input logic [2:0] kind, input logic [23:0] len);
        push_byte({5'd0, kind});
        push_byte(len[7:0]);
        push_byte(len[15:8]);
        push_byte(len[23:16]);
    endfunction

    // Mostly well-formed files with random content; some noise and cut-off files
    function automatic void build_random_file();
        int unsigned pick;
        int unsigned nblk;
        int unsigned len;
        int unsigned off;
        int unsigned cut;
        logic [2:0]  kind;
        logic [7:0]  b;
        pick = $urandom_range(99);
        if (pick < 5) begin
            repeat ($urandom_range(1, 40)) push_byte(8'($urandom));
            return;
        end
        pick = $urandom_range(99);
        if (pick < 55)      off = 22;
        else if (pick < 70) off = $urandom_range(23, 40);
        else if (pick < 85) off = $urandom_range(0, 21);
        else if (pick < 97) off = $urandom_range(41, 80);
        else                off = $urandom_range(256, 300);
        push_header(off[15:0]);
        nblk = $urandom_range(1, 6);
        repeat (nblk) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                kind = BK_SOUND;
                pick = $urandom_range(9);
                len = (pick < 3) ? pick : $urandom_range(3, 20);
            end else if (pick < 45) begin
                kind = BK_CONT;
                len = ($urandom_range(99) < 3) ? $urandom_range(256, 300)
                                               : $urandom_range(0, 16);
            end else if (pick < 60) begin
                kind = BK_SILENCE;
                len = $urandom_range(0, 5);
            end else if (pick < 70) begin
                kind = BK_REPEAT;
                len = $urandom_range(0, 2);
            end else if (pick < 80) begin
                kind = BK_END_REP;
                len = $urandom_range(0, 2);
            end else begin
                kind = $urandom_range(1) ? BLK_MARKER : BLK_TEXT;
                len = $urandom_range(0, 8);
            end
            push_block_head(kind, len[23:0]);
            for (int i = 0; i < int'(len); i++) begin
                b = 8'($urandom);
                // Bias the time constant toward the rate extremes and the remapped rate
                if (kind == BK_SOUND && i == 0) begin
                    case ($urandom_range(4))
                        0: b = 8'd0;
                        1: b = 8'd255;
                        2, 3: b = TC_REMAP;
                        default: ;
                    endcase
                end
                push_byte(b);
            end
        end
        pick = $urandom_range(99);
        if (pick < 60) begin
            push_byte($urandom_range(1) ? TYPE_END : 8'($urandom_range(8, 255)));
            repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
        end else if (pick >= 85) begin
            cut = $urandom_range(1, feed.size());
            while (feed.size() > cut) void'(feed.pop_back());
        end
    endfunction

    task automatic send_byte(input logic [7:0] value, input bit fin);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.parse_byte(value, fin);
    endtask

    // Mark the final byte and stream the whole file
    task automatic send_file();
        if (feed.size() == 0) return;
        feed[$].fin = 1'b1;
        for (int i = 0; i < feed.size(); i++) send_byte(feed[i].value, feed[i].fin);
        feed.delete();
        files_sent++;
    endtask

    // Write the remap register once the parser has drained
    task automatic write_rate_remap(input bit value);
        s_axis_tvalid <= 1'b0;
        while (sb.parsed_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.remap_en = value;
    endtask

    initial begin
        int target;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A file that is only its final byte
        push_byte(8'hFF);
        send_file();

        // Clamped offset; every block type but text once; loop marks; bytes after the end
        push_header(16'h0000);
        push_block_head(BK_SOUND, 24'd4);
        push_byte(TC_REMAP);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_block_head(BK_SILENCE, 24'd3);
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_byte(8'h55);
        push_block_head(BK_REPEAT, 24'd0);
        push_block_head(BK_CONT, 24'd2);
        push_byte(8'h80);
        push_byte(8'h7F);
        push_block_head(BK_END_REP, 24'd2);
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_block_head(BLK_MARKER, 24'd1);
        push_byte(8'hAA);
        push_byte(TYPE_END);
        push_byte(8'h12);
        push_byte(8'h34);
        send_file();

        // Skipped header byte; short sound and silence blocks; rate extremes
        push_header(16'd23);
        push_block_head(BK_SOUND, 24'd0);
        push_block_head(BK_SOUND, 24'd1);
        push_byte(8'h00);
        push_block_head(BK_SOUND, 24'd3);
        push_byte(8'hFF);
        push_byte(8'h01);
        push_byte(8'h02);
        push_block_head(BK_SILENCE, 24'd1);
        push_byte(8'h10);
        push_block_head(BK_SILENCE, 24'd2);
        push_byte(8'h00);
        push_byte(8'h00);
        push_block_head(BLK_TEXT, 24'd0);
        push_byte(8'hFF);
        send_file();

        // File cut off on a sample: sample and summary from one byte
        push_header(16'd22);
        push_block_head(BK_CONT, 24'd5);
        push_byte(8'h01);
        push_byte(8'hFE);
        push_byte(8'h40);
        send_file();

        // Random files under four handshake mixes, remap toggled each phase
        for (int p = 0; p < 4; p++) begin
            write_rate_remap(p % 2 == 0);
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            target = sb.bytes_parsed + PHASE_BYTES;
            while (sb.bytes_parsed < target) begin
                build_random_file();
                send_file();
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain and let the parser settle
        while (sb.parsed_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("Parsed %0d file bytes in %0d files, rate remap on and off, %s",
                 sb.bytes_parsed, files_sent, "four handshake mixes");
        $display("Checked %0d results: %0d samples, %0d silence, %0d rate, %0d loop start, %s",
                 sb.checked, sb.kinds_seen[0], sb.kinds_seen[1], sb.kinds_seen[2],
                 sb.kinds_seen[3],
                 $sformatf("%0d loop end, %0d summary", sb.kinds_seen[4], sb.kinds_seen[5]));
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- voc_block_stream_parser.f -----
src/vbsp_pkg.sv
src/vbsp_div.sv
src/vbsp_out.sv
src/voc_block_stream_parser.sv
tb/tb_voc_block_stream_parser.sv
